FILE: sv/xfd_pkg.sv
// Shared types and constants for the XOR-checksum frame deframer.
// No dependencies; imported by xfd_parser and xor_frame_deframer_top.
`timescale 1ns / 1ps

package xfd_pkg;

  // Register indexes on the configuration port
  localparam logic [7:0] CFG_MAX_LEN = 8'd0;
  localparam logic [7:0] CFG_HEAD1   = 8'd1;
  localparam logic [7:0] CFG_HEAD2   = 8'd2;
  localparam logic [7:0] CFG_END     = 8'd3;

  // Register reset values
  localparam logic [7:0] RST_MAX_LEN = 8'd128;
  localparam logic [7:0] RST_HEAD1   = 8'hAA;
  localparam logic [7:0] RST_HEAD2   = 8'h55;
  localparam logic [7:0] RST_END     = 8'hEE;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_OK     = 3'd1,
    KIND_LONG   = 3'd2,
    KIND_CSUM   = 3'd3,
    KIND_ENDERR = 3'd4
  } kind_t;

  // Parser phases, one-hot
  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_HEAD2   = 7'b0000010,
    PH_ID      = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CHECK   = 7'b0100000,
    PH_END     = 7'b1000000
  } phase_t;

  // Configuration registers as seen by the parser
  typedef struct packed {
    logic [7:0] max_len;
    logic [7:0] head1;
    logic [7:0] head2;
    logic [7:0] end_byte;
  } cfg_t;

  // One parser result word
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] id;
    logic [7:0] length;
    logic [7:0] index;
    logic [7:0] data;
  } result_t;

endpackage

FILE: sv/xfd_parser.sv
// Frame parser: phase register, frame context and the per-byte step logic.
// Depends on xfd_pkg.
`timescale 1ns / 1ps

module xfd_parser import xfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] count_inc;

  assign count_inc = payload_count + 8'd1;

  // One step of the frame walk
  always_comb begin
    phase_next         = phase;
    held_id_next       = held_id;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    res.valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.id             = held_id;
    res.length         = held_length;
    res.index          = 8'd0;
    res.data           = 8'd0;
    case (phase)
      PH_HEAD2: begin
        phase_next = (rx_byte == cfg.head2) ? PH_ID : PH_HUNT;
      end
      PH_ID: begin
        held_id_next = rx_byte;
        phase_next   = PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte > cfg.max_len) begin
          res.valid  = 1'b1;
          res.kind   = KIND_LONG;
          res.length = rx_byte;
          phase_next = PH_HUNT;
        end else begin
          held_length_next   = rx_byte;
          payload_count_next = 8'd0;
          running_xor_next   = 8'd0;
          phase_next         = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.valid          = 1'b1;
        res.kind           = KIND_DATA;
        res.index          = payload_count;
        res.data           = rx_byte;
        running_xor_next   = running_xor ^ rx_byte;
        payload_count_next = count_inc;
        if (count_inc >= held_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (rx_byte != running_xor) begin
          res.valid  = 1'b1;
          res.kind   = KIND_CSUM;
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        res.valid  = 1'b1;
        res.kind   = (rx_byte == cfg.end_byte) ? KIND_OK : KIND_ENDERR;
        phase_next = PH_HUNT;
      end
      default: begin
        // hunting, and any stray phase code
        phase_next = (rx_byte == cfg.head1) ? PH_HEAD2 : PH_HUNT;
      end
    endcase
  end

  // State update on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      held_id       <= 8'd0;
      held_length   <= 8'd0;
      payload_count <= 8'd0;
      running_xor   <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      held_id       <= held_id_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
    end
  end

endmodule

FILE: sv/xor_frame_deframer_top.sv
// Top level of the XOR-checksum frame deframer: config registers, input
// and result registers around xfd_parser. Depends on xfd_pkg, xfd_parser.
`timescale 1ns / 1ps
//
// Usage:
//   Received bytes arrive on the in_valid/in_ready channel (rx_byte), one
//   word per handshake. Results leave on out_valid/out_ready with
//   result_kind, packet_id, frame_length, byte_index and data_byte: one word
//   for each payload byte, and one status word at the end of each frame or
//   on a length, checksum or end byte error. Header, id, length and a good
//   checksum byte give no result.
//   Configuration is written on cfg_valid/cfg_ready (always ready) with
//   cfg_index 0..3 and cfg_data; other indexes are ignored. Write only while
//   the block is idle.
//   A result is registered: the byte sits in the input register, and the
//   result register loads when the stage advances. Throughput: one byte per
//   cycle while the receiver takes results, set by the step from the input
//   register into the result register and the parser state.
//   Reset (rst, synchronous) sets the parser to hunting for the first header
//   byte and loads the default config. When the receiver stalls, the result
//   register holds its word and in_ready drops once the input register holds
//   a byte; an empty input register still takes one further byte first.

module xor_frame_deframer_top import xfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] result_kind,
  output logic [7:0] packet_id,
  output logic [7:0] frame_length,
  output logic [7:0] byte_index,
  output logic [7:0] data_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t       cfg;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       advance;
  result_t    res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len  <= RST_MAX_LEN;
      cfg.head1    <= RST_HEAD1;
      cfg.head2    <= RST_HEAD2;
      cfg.end_byte <= RST_END;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_LEN: cfg.max_len  <= cfg_data;
        CFG_HEAD1:   cfg.head1    <= cfg_data;
        CFG_HEAD2:   cfg.head2    <= cfg_data;
        CFG_END:     cfg.end_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage advances when the result register is free or being emptied
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= rx_byte;
    end
  end

  xfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (stage_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      result_kind  <= res.kind;
      packet_id    <= res.id;
      frame_length <= res.length;
      byte_index   <= res.index;
      data_byte    <= res.data;
    end
  end

endmodule
